@@ hw/rtl/lpl_pkg.sv @@
// Package for the lookahead peak limiter: widths, register indexes,
// controller command and status structures. No dependencies.
package lpl_pkg;

   localparam int RingDepthDef  = 256;
   localparam int ChannelsDef   = 2;
   localparam int SampleBitsDef = 24;

   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = 25;
   localparam int LaBits      = 8;
   localparam int RelBits     = 25;
   localparam int GainBits    = 24;

   localparam logic [CsrIdxBits-1:0] CSR_CEILING   = 2'd0;
   localparam logic [CsrIdxBits-1:0] CSR_RELEASE   = 2'd1;
   localparam logic [CsrIdxBits-1:0] CSR_LOOKAHEAD = 2'd2;

   localparam logic [GainBits-1:0] GainUnity = 24'h80_0000;
   localparam logic [24:0]         RelOne    = 25'h100_0000;
   localparam logic [CsrDataBits-1:0] RelReset = 25'd5825;
   localparam logic [LaBits-1:0]      LaReset  = 8'd240;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;   // clear the ring at the clear address
      logic pos_wrap;     // bring the write position into the ring
      logic load;         // capture the input word and derive positions
      logic write_ring;   // write samples and peak at the write position
      logic scan_start;   // reset scan pointer and window maximum
      logic scan_step;    // fold one peak entry into the window maximum
      logic div_start;    // set up the gain division
      logic div_step;     // one quotient bit
      logic gain_update;  // attack or release update
      logic read_delay;   // read the delayed samples
      logic mult;         // form the output products
      logic out_load;     // load the output register
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic pos_ok;
      logic scan_done;
      logic div_done;
   } ctl_sts_type;

endpackage

@@ hw/rtl/lpl_ctrl.sv @@
// Sequencing controller of the lookahead peak limiter.
// Depends on lpl_pkg.
module lpl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  lpl_pkg::ctl_sts_type sts,
   output lpl_pkg::ctl_cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b00_0000_0001,
      ST_IDLE  = 10'b00_0000_0010,
      ST_WRITE = 10'b00_0000_0100,
      ST_SCAN  = 10'b00_0000_1000,
      ST_DIVS  = 10'b00_0001_0000,
      ST_DIV   = 10'b00_0010_0000,
      ST_GAIN  = 10'b00_0100_0000,
      ST_READ  = 10'b00_1000_0000,
      ST_MULT  = 10'b01_0000_0000,
      ST_OUT   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Output register is free once the held word is taken.
   logic out_free;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && sts.pos_ok;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!sts.pos_ok) begin
               cmd.pos_wrap = 1'b1;
            end else if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_ring = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain_update = 1'b1;
            state_in        = ST_READ;
         end
         ST_READ: begin
            cmd.read_delay = 1'b1;
            state_in       = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/lpl_datapath.sv @@
// Datapath of the lookahead peak limiter: rings, window scan, restoring
// divider, gain smoothing and output multipliers. Depends on lpl_pkg.
module lpl_datapath #(
   parameter int RING_DEPTH  = lpl_pkg::RingDepthDef,
   parameter int CHANNELS    = lpl_pkg::ChannelsDef,
   parameter int SAMPLE_BITS = lpl_pkg::SampleBitsDef
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [lpl_pkg::CsrIdxBits-1:0]       csr_index,
   input  logic [lpl_pkg::CsrDataBits-1:0]      csr_write_data,
   input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] req_samples,
   output logic [CHANNELS-1:0][SAMPLE_BITS-1:0] rsp_samples,
   input  lpl_pkg::ctl_cmd_type                 cmd,
   output lpl_pkg::ctl_sts_type                 sts
);

   localparam int AddrBits = $clog2(RING_DEPTH);
   localparam int CntBits  = AddrBits + 1;
   localparam int Sb       = SAMPLE_BITS;
   localparam int DivBits  = 2 * Sb;
   localparam int QBits    = Sb + 1;
   localparam int CntDiv   = $clog2(QBits + 1);
   localparam int DivStepsI = QBits;
   localparam logic [CntDiv-1:0] DivSteps = CntDiv'(DivStepsI);
   localparam logic [Sb-1:0] FullScale = {1'b1, {(Sb-1){1'b0}}};
   localparam logic [CntBits-1:0] MaxLa = CntBits'(RING_DEPTH - 1);

   // Configuration registers.
   logic [lpl_pkg::GainBits-1:0] ceil_ff;
   logic [lpl_pkg::RelBits-1:0]  rel_ff;
   logic [lpl_pkg::LaBits-1:0]   la_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceil_ff <= lpl_pkg::GainUnity;
         rel_ff  <= lpl_pkg::RelReset;
         la_ff   <= lpl_pkg::LaReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            lpl_pkg::CSR_CEILING:   ceil_ff <= csr_write_data[lpl_pkg::GainBits-1:0];
            lpl_pkg::CSR_RELEASE:   rel_ff  <= csr_write_data[lpl_pkg::RelBits-1:0];
            lpl_pkg::CSR_LOOKAHEAD: la_ff   <= csr_write_data[lpl_pkg::LaBits-1:0];
            default: ;
         endcase
      end
   end

   // Effective ring length minus one, saturated to the store.
   logic [CntBits-1:0] la_ext, la_eff;
   always_comb begin
      la_ext = (CntBits >= lpl_pkg::LaBits) ? CntBits'(la_ff)
             : ((la_ff > lpl_pkg::LaBits'(RING_DEPTH - 1)) ? MaxLa : CntBits'(la_ff));
      la_eff = (la_ext > MaxLa) ? MaxLa : la_ext;
   end

   // Effective ceiling, Sb wide, one to full scale.
   logic [Sb-1:0] ceil_eff;
   always_comb begin
      if (ceil_ff == '0)
         ceil_eff = Sb'(1);
      else if (lpl_pkg::GainBits'(ceil_ff) > lpl_pkg::GainBits'(FullScale))
         ceil_eff = FullScale;
      else
         ceil_eff = Sb'(ceil_ff);
   end

   logic [24:0] rel_eff;
   assign rel_eff = (rel_ff > lpl_pkg::RelOne) ? lpl_pkg::RelOne : rel_ff;

   // Memories.
   logic [Sb-1:0] delay_mem [CHANNELS][RING_DEPTH];
   logic [Sb-1:0] peak_mem  [RING_DEPTH];

   // Ring positions and captured word.
   logic [AddrBits-1:0] wpos_ff, pos_ff, rd_ff, clr_ff;
   logic [CHANNELS-1:0][Sb-1:0] smp_ff;
   logic [Sb-1:0] fpeak_ff;

   // Current and delayed positions. A word is only taken once the write
   // position lies inside the ring, so no reduction is needed here.
   logic [AddrBits-1:0] pos_c, rd_c;
   always_comb begin
      pos_c = (CntBits'(wpos_ff) > la_eff) ? '0 : wpos_ff;
      rd_c  = (CntBits'(pos_c) == la_eff) ? '0 : AddrBits'(CntBits'(pos_c) + 1'b1);
   end
   assign sts.pos_ok = (CntBits'(wpos_ff) <= la_eff);

   // Frame peak over all channels.
   logic [Sb-1:0] fpeak_c;
   always_comb begin
      logic [Sb-1:0] mag;
      fpeak_c = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         mag = req_samples[c][Sb-1] ? (~req_samples[c] + 1'b1) : req_samples[c];
         if (mag > fpeak_c) fpeak_c = mag;
      end
   end

   // After a lookahead change the write position is reduced modulo the new
   // ring length by subtracting the length once a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0;
         clr_ff  <= '0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.write_ring) wpos_ff <= rd_ff;
         else if (cmd.pos_wrap)
            wpos_ff <= AddrBits'(CntBits'(wpos_ff) - (la_eff + 1'b1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         smp_ff   <= req_samples;
         fpeak_ff <= fpeak_c;
         pos_ff   <= pos_c;
         rd_ff    <= rd_c;
      end
   end

   // Ring writes: clearing pass or a new frame.
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         for (int c = 0; c < CHANNELS; c++) delay_mem[c][clr_ff] <= '0;
         peak_mem[clr_ff] <= '0;
      end else if (cmd.write_ring) begin
         for (int c = 0; c < CHANNELS; c++) delay_mem[c][pos_ff] <= smp_ff[c];
         peak_mem[pos_ff] <= fpeak_ff;
      end
   end
   assign sts.clear_done = (clr_ff == AddrBits'(RING_DEPTH - 1));

   // Window scan: one peak entry per cycle, read data registered.
   logic [CntBits-1:0] scan_ff;
   logic [Sb-1:0]      pk_rd_ff, win_ff;
   logic               pk_vld_ff;
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_ff   <= '0;
         win_ff    <= '0;
         pk_vld_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (scan_ff <= la_eff) begin
            pk_rd_ff <= peak_mem[scan_ff[AddrBits-1:0]];
            scan_ff  <= scan_ff + 1'b1;
         end
         pk_vld_ff <= (scan_ff <= la_eff);
         if (pk_vld_ff && pk_rd_ff > win_ff) win_ff <= pk_rd_ff;
      end
   end
   assign sts.scan_done = (scan_ff > la_eff) && !pk_vld_ff;

   // Restoring division (ceil << (Sb-1)) / max(win, ceil), one bit a cycle.
   // The quotient fits QBits since ceil <= den, so the dividend bits above
   // the lowest QBits are preloaded into the remainder.
   logic [DivBits-1:0] dividend;
   logic [DivBits-1:0] num_ff;
   logic [Sb:0]        rem_ff;
   logic [Sb-1:0]      den_ff;
   logic [QBits-1:0]   quo_ff;
   logic [CntDiv-1:0]  dcnt_ff;
   logic [Sb:0]        rem_sh;
   assign dividend = {1'b0, ceil_eff, {(Sb-1){1'b0}}};
   always_comb rem_sh = {rem_ff[Sb-1:0], num_ff[DivBits-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff  <= dividend << (DivBits - QBits);
         rem_ff  <= (Sb+1)'(dividend >> QBits);
         den_ff  <= (win_ff > ceil_eff) ? win_ff : ceil_eff;
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step && dcnt_ff != DivSteps) begin
         num_ff  <= num_ff << 1;
         dcnt_ff <= dcnt_ff + 1'b1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            quo_ff <= {quo_ff[QBits-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[QBits-2:0], 1'b0};
         end
      end
   end
   assign sts.div_done = (dcnt_ff == DivSteps);

   // Gain smoothing: instant attack, first-order release.
   logic [Sb-1:0] gain_ff;
   logic [Sb-1:0] req_g;
   logic [Sb-1:0] diff;
   logic [Sb+24:0] rel_prod;
   assign req_g    = Sb'(quo_ff);
   assign diff     = req_g - gain_ff;
   assign rel_prod = diff * rel_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= FullScale;
      end else if (cmd.gain_update) begin
         if (req_g < gain_ff) gain_ff <= req_g;
         else gain_ff <= gain_ff + Sb'(rel_prod >> 24);
      end
   end

   // Delayed samples and output products.
   logic [CHANNELS-1:0][Sb-1:0] dly_ff;
   logic [CHANNELS-1:0][2*Sb-1:0] prod_ff;
   logic [CHANNELS-1:0] neg_ff;
   logic [CHANNELS-1:0][Sb-1:0] res_ff;

   always_ff @(posedge clock) begin
      if (cmd.read_delay)
         for (int c = 0; c < CHANNELS; c++) dly_ff[c] <= delay_mem[c][rd_ff];
   end

   always_ff @(posedge clock) begin
      logic [Sb-1:0] mag;
      if (cmd.mult) begin
         for (int c = 0; c < CHANNELS; c++) begin
            mag        = dly_ff[c][Sb-1] ? (~dly_ff[c] + 1'b1) : dly_ff[c];
            prod_ff[c] <= (2*Sb)'(mag) * (2*Sb)'(gain_ff);
            neg_ff[c]  <= dly_ff[c][Sb-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [2*Sb-1:0] q;
      if (cmd.out_load) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (neg_ff[c]) begin
               q = (prod_ff[c] + (2*Sb)'(FullScale - 1'b1)) >> (Sb - 1);
               res_ff[c] <= Sb'(~q + 1'b1);
            end else begin
               q = prod_ff[c] >> (Sb - 1);
               res_ff[c] <= Sb'(q);
            end
         end
      end
   end
   assign rsp_samples = res_ff;

endmodule

@@ hw/rtl/lookahead_peak_limiter.sv @@
// Top level of the lookahead peak limiter: ties the controller to the
// datapath. Depends on lpl_pkg, lpl_ctrl and lpl_datapath.
//
// Usage: one stereo input word (req_) gives exactly one output word (rsp_),
// the left and right samples written lookahead_samples words earlier,
// scaled by the smoothed limiter gain. Both channels use valid/ready.
// Configuration must be written through csr_ only while the block is idle;
// the block itself does not enforce this. Processing: a taken word is
// written to the rings, the peak ring is scanned, the gain is found by
// bit-serial division and updated, the delayed samples are read and
// multiplied, and the result enters the output register. The next word can
// be taken in the cycle after that load. L being the ring length
// (lookahead_samples + 1), after a lookahead change the write position is
// first brought into the new ring, one subtraction of L a cycle, before a
// word is taken. Reset: a clearing pass zeroes every ring entry; no word is
// accepted until it ends. Gain resets to unity.
// A stalled receiver holds the output word; the block stops before loading
// the next result until the held word has been taken.
module lookahead_peak_limiter #(
   parameter int RING_DEPTH  = lpl_pkg::RingDepthDef,
   parameter int SAMPLE_BITS = lpl_pkg::SampleBitsDef
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [lpl_pkg::CsrIdxBits-1:0]    csr_index,
   input  logic [lpl_pkg::CsrDataBits-1:0]   csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_left,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_right,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]     rsp_limited_left,
   output logic signed [SAMPLE_BITS-1:0]     rsp_limited_right
);

   lpl_pkg::ctl_cmd_type cmd;
   lpl_pkg::ctl_sts_type sts;
   logic [lpl_pkg::ChannelsDef-1:0][SAMPLE_BITS-1:0] in_w, out_w;

   // Channel ports map onto the two lanes.
   always_comb begin
      in_w    = '0;
      in_w[0] = req_sample_left;
      in_w[lpl_pkg::ChannelsDef-1] = req_sample_right;
   end
   assign rsp_limited_left  = out_w[0];
   assign rsp_limited_right = out_w[lpl_pkg::ChannelsDef-1];

   lpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpl_datapath #(
      .RING_DEPTH  (RING_DEPTH),
      .CHANNELS    (lpl_pkg::ChannelsDef),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_samples      (in_w),
      .rsp_samples      (out_w),
      .cmd              (cmd),
      .sts              (sts)
   );

   // A held result is only replaced at the edge where it is taken.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("output overrun");

   // Input is taken only with no internal work under way.
   a_single: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word taken during processing");

   // Commands never overlap between the ring write and the clearing pass.
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_step && cmd.write_ring))
      else $error("clear and write together");

endmodule

@@ sim/lpl_checker.sv @@
// Checker for the lookahead peak limiter: watches the config port and both
// channels, predicts each output word and compares it. Depends on lpl_pkg.
`timescale 1ns / 100ps
module lpl_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [lpl_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [lpl_pkg::CsrDataBits-1:0] csr_write_data,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic signed [23:0]              req_sample_left,
   input  logic signed [23:0]              req_sample_right,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic signed [23:0]              rsp_limited_left,
   input  logic signed [23:0]              rsp_limited_right,
   output int                              fail_count,
   output int                              pending
);

   typedef struct packed {
      logic [23:0] left;
      logic [23:0] right;
   } frame_type;

   logic [23:0] ceil_reg;
   logic [24:0] rel_reg;
   logic [7:0]  la_reg;
   logic [23:0] left_ring [256];
   logic [23:0] right_ring [256];
   logic [23:0] peak_ring [256];
   logic [7:0]  wr_pos;
   logic [23:0] gain;
   frame_type   expected_words [$];

   function automatic logic [23:0] magnitude(logic signed [23:0] s);
      logic [24:0] m;
      m = (s < 0) ? -25'(s) : 25'(s);
      return m[23:0];
   endfunction

   // Gain times sample, shifted down by 23 and rounded towards minus infinity.
   function automatic logic [23:0] scale(logic signed [23:0] s, logic [23:0] g);
      logic signed [49:0] p;
      p = 50'(s) * $signed({26'd0, g});
      return p[46:23];
   endfunction

   task automatic limit_word(logic [23:0] l, logic [23:0] r);
      int unsigned len, pos, rd;
      logic [23:0] pk, win, ml, mr;
      logic [47:0] c, req, diff;
      logic [24:0] rel;
      frame_type w;
      len = int'(la_reg) + 1;
      pos = wr_pos % len;
      left_ring[pos] = l;
      right_ring[pos] = r;
      ml = magnitude(l);
      mr = magnitude(r);
      pk = (ml > mr) ? ml : mr;
      peak_ring[pos] = pk;
      rd = (pos + 1) % len;
      win = 0;
      for (int k = 0; k < len; k++) if (peak_ring[k] > win) win = peak_ring[k];
      c = (ceil_reg == 0) ? 48'd1 : 48'(ceil_reg);
      if (c > 48'h80_0000) c = 48'h80_0000;
      req = (c << 23) / ((48'(win) > c) ? 48'(win) : c);
      rel = (rel_reg > lpl_pkg::RelOne) ? lpl_pkg::RelOne : rel_reg;
      if (req < 48'(gain)) gain = req[23:0];
      else begin
         diff = req - 48'(gain);
         gain = gain + 24'((diff * 48'(rel)) >> 24);
      end
      w.left = scale(left_ring[rd], gain);
      w.right = scale(right_ring[rd], gain);
      expected_words.push_back(w);
      wr_pos = 8'(rd);
   endtask

   task automatic report(string what, logic [23:0] got, logic [23:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // Track configuration, predict on each accepted input, check each output.
   always @(posedge clock) begin
      frame_type w;
      if (reset) begin
         ceil_reg <= 24'h80_0000;
         rel_reg <= lpl_pkg::RelReset;
         la_reg <= lpl_pkg::LaReset;
         wr_pos = 0;
         gain = lpl_pkg::GainUnity;
         fail_count = 0;
         pending = 0;
         for (int k = 0; k < 256; k++) begin
            left_ring[k] = 0; right_ring[k] = 0; peak_ring[k] = 0;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               lpl_pkg::CSR_CEILING:   ceil_reg <= csr_write_data[23:0];
               lpl_pkg::CSR_RELEASE:   rel_reg <= csr_write_data;
               lpl_pkg::CSR_LOOKAHEAD: la_reg <= csr_write_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) limit_word(req_sample_left, req_sample_right);
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("unexpected output word at %0t", $time);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_limited_left !== w.left) report("left", rsp_limited_left, w.left);
               if (rsp_limited_right !== w.right)
                  report("right", rsp_limited_right, w.right);
            end
         end
         pending = expected_words.size();
      end
   end

endmodule

@@ sim/tb.sv @@
// Testbench top for the lookahead peak limiter: drives words and register
// writes, gives the verdict. Depends on lpl_pkg, lpl_checker and the RTL.
`timescale 1ns / 100ps
module tb;

   // An index that names no register.
   localparam logic [lpl_pkg::CsrIdxBits-1:0] CsrUnused = 2'd3;

   logic clock, reset;
   logic csr_write_enable;
   logic [lpl_pkg::CsrIdxBits-1:0] csr_index;
   logic [lpl_pkg::CsrDataBits-1:0] csr_write_data;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [23:0] req_sample_left, req_sample_right;
   logic signed [23:0] rsp_limited_left, rsp_limited_right;
   int fail_count, pending;
   int unsigned cycle_count = 0;

   lookahead_peak_limiter u_dut (.*);
   lpl_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Cycle limit: ~1700 words, plus long gaps and receiver stalls, with a wide margin.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 10_000_000) begin
         $display("FAIL lookahead_peak_limiter");
         $finish;
      end
   end

   // Receiver stalls: mostly short, sometimes long, sometimes none.
   initial begin
      int n;
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0) n = 0;
         rsp_ready <= (n == 0);
         if (n != 0) begin
            repeat (n) @(posedge clock);
            rsp_ready <= 1;
         end
      end
   end

   function automatic logic [23:0] pick_sample(int mode);
      case (mode)
         0: return 24'($urandom());
         1: return 24'($signed($urandom_range(0, 4000)) - 2000);
         2: return $urandom_range(0, 1) ? 24'h7f_ffff : 24'h80_0000;
         default: return 24'($signed($urandom_range(0, 2 * 800000)) - 800000);
      endcase
   endfunction

   // Idle time between words; valid drops only when there is a gap.
   task automatic gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 600) : $urandom_range(0, 2);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_word(logic [23:0] l, logic [23:0] r);
      req_valid <= 1;
      req_sample_left <= l;
      req_sample_right <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(logic [lpl_pkg::CsrIdxBits-1:0] idx,
                            logic [lpl_pkg::CsrDataBits-1:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   initial begin
      int mode;
      reset = 1;
      csr_write_enable = 0;
      csr_index = 0;
      csr_write_data = 0;
      req_valid = 0;
      req_sample_left = 0;
      req_sample_right = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // Directed words: extremes, most negative sample, short lookahead.
      write_reg(lpl_pkg::CSR_LOOKAHEAD, 25'd3);
      send_word(24'h7f_ffff, 24'h80_0000);
      send_word(24'h80_0000, 24'h00_0000);
      send_word(24'h00_0000, 24'h7f_ffff);
      send_word(24'hff_ffff, 24'h00_0001);
      for (int i = 0; i < 6; i++) send_word(24'h00_1000, 24'hff_f000);
      drain();
      // Zero ceiling, release above one, unknown index, lookahead zero.
      write_reg(lpl_pkg::CSR_CEILING, 25'd0);
      write_reg(lpl_pkg::CSR_RELEASE, 25'h1ff_ffff);
      write_reg(CsrUnused, 25'h1ff_ffff);
      write_reg(lpl_pkg::CSR_LOOKAHEAD, 25'd0);
      for (int i = 0; i < 4; i++) send_word(24'h40_0000, 24'hc0_0000);
      drain();
      // Ceiling above full scale saturates; lookahead at its maximum.
      write_reg(lpl_pkg::CSR_CEILING, 25'hff_ffff);
      write_reg(lpl_pkg::CSR_RELEASE, 25'd0);
      write_reg(lpl_pkg::CSR_LOOKAHEAD, 25'd255);
      for (int i = 0; i < 4; i++) send_word(24'h7f_0000, 24'h01_0000);
      drain();

      // Random phases through several settings; lookahead mostly short.
      for (int ph = 0; ph < 17; ph++) begin
         write_reg(lpl_pkg::CSR_CEILING, (ph % 5 == 0) ? 25'd1 :
                   (ph % 5 == 1) ? 25'h80_0000 : 25'($urandom_range(1, 24'hff_ffff)));
         write_reg(lpl_pkg::CSR_RELEASE, (ph % 4 == 0) ? 25'h100_0000 :
                   (ph % 4 == 1) ? 25'd0 : 25'($urandom_range(0, 25'h1ff_ffff)));
         write_reg(lpl_pkg::CSR_LOOKAHEAD, (ph == 8) ? 25'd255 : (ph == 3) ? 25'd0 :
                   25'($urandom_range(0, 20)));
         mode = ph % 4;
         for (int i = 0; i < 100; i++) begin
            gap();
            send_word(pick_sample($urandom_range(0, 4) == 0 ? 0 : mode),
                      pick_sample($urandom_range(0, 4) == 0 ? 0 : mode));
            if (i == 50 && ph == 5) drain();
         end
         drain();
      end

      if (fail_count == 0) $display("PASS lookahead_peak_limiter");
      else $display("FAIL lookahead_peak_limiter");
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/lpl_pkg.sv
hw/rtl/lpl_ctrl.sv
hw/rtl/lpl_datapath.sv
hw/rtl/lookahead_peak_limiter.sv
sim/lpl_checker.sv
sim/tb.sv
